// ===== sv/ignition_dwell_compare_scheduler_macros.svh =====
// Assertion macros used by the checker file of the dwell scheduler.
`ifndef IGNITION_DWELL_COMPARE_SCHEDULER_MACROS_SVH
`define IGNITION_DWELL_COMPARE_SCHEDULER_MACROS_SVH

// A property that is checked only outside reset.
`define IDCS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property that is checked at every clock edge, reset included.
`define IDCS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/idcs_pkg.sv =====
package idcs_pkg;

  typedef enum logic [1:0] {
    ST_OFF     = 2'd0,
    ST_PENDING = 2'd1,
    ST_RUNNING = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_SCHEDULE = 2'd1,
    CMD_CLEAR    = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_t;

  localparam logic REG_CHANNEL_LIMIT = 1'b0;
  localparam logic REG_MIN_DELAY     = 1'b1;

  localparam logic [1:0]  CHANNEL_LIMIT_RESET = 2'd2;
  localparam logic [9:0]  MIN_DELAY_RESET     = 10'd25;
  localparam logic [15:0] COMPARE_RESET       = 16'hFFFF;

  localparam logic [1:0] CHANNEL_COIL_ONE = 2'd1;
  localparam logic [1:0] CHANNEL_COIL_TWO = 2'd2;

  // Slot state after a compare match.
  typedef struct packed {
    status_t     status;
    logic        coil;
    logic [15:0] compare;
  } slot_upd_t;

  // True when (a - b) taken as a signed 16-bit value is not negative.
  function automatic logic reached(logic [15:0] a, logic [15:0] b);
    logic [15:0] d;
    d = a - b;
    return ~d[15];
  endfunction

endpackage

// ===== sv/ignition_dwell_compare_scheduler.sv =====
// Channel   Handshake             Payload
// --------  --------------------  ---------------------------------------------------
// input     in_valid / in_ready   command, channel, start_us, duration_us
// result    out_valid / out_ready coil_one, coil_two, status_one, status_two, timer_count
// config    cfg_write             cfg_index, cfg_data
//
// One item per clock cycle while results are taken: an item is captured in the input
// register, processed there, and its result lands in the result register as it leaves.
// The slot state is updated in the cycle the item leaves the input register.
// A stalled result holds the result register; the input register keeps accepting until it
// too is full. Reset clears the timer, turns both slots off and both coils off.
module ignition_dwell_compare_scheduler #(
  parameter int TICK_SHIFT = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [1:0]  channel,
  input  logic [23:0] start_us,
  input  logic [15:0] duration_us,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        coil_one,
  output logic        coil_two,
  output logic [1:0]  status_one,
  output logic [1:0]  status_two,
  output logic [15:0] timer_count,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_data
);
  import idcs_pkg::*;

  // Configuration.
  logic [1:0] channel_limit;
  logic [9:0] min_delay_us;

  // Input register.
  logic        in_full;
  cmd_t        cmd_q;
  logic [1:0]  chan_q;
  logic [23:0] start_q;
  logic [15:0] dur_q;

  // Scheduler state.
  logic [15:0] cnt, cnt_next;
  status_t     status [2];
  status_t     status_next [2];
  logic        coil [2];
  logic        coil_next [2];
  logic [15:0] cmp [2];
  logic [15:0] cmp_next [2];
  logic [15:0] end_cmp [2];
  logic [15:0] end_cmp_next [2];
  logic [1:0]  slot_chan [2];
  logic [1:0]  slot_chan_next [2];

  logic advance;
  logic sel;

  // Schedule arithmetic.
  logic [23:0] st_ticks;
  logic [15:0] du_raw;
  logic [15:0] du_ticks;
  logic [24:0] total;
  logic [23:0] mn_ticks;
  logic        clamp;
  logic [24:0] rest;
  logic [15:0] st16;
  logic [15:0] du16;
  logic [15:0] start_new;
  logic [15:0] end_new;

  slot_upd_t tick_upd [2];
  slot_upd_t sched_upd;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;
  assign sel      = (chan_q != CHANNEL_COIL_ONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_limit <= CHANNEL_LIMIT_RESET;
      min_delay_us  <= MIN_DELAY_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CHANNEL_LIMIT: channel_limit <= cfg_data[1:0];
        REG_MIN_DELAY:     min_delay_us  <= cfg_data;
        default:           ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd_q   <= cmd_t'(command);
      chan_q  <= channel;
      start_q <= start_us;
      dur_q   <= duration_us;
    end
  end

  // Microseconds to ticks, with the minimum-delay clamp.
  always_comb begin
    st_ticks = start_q >> TICK_SHIFT;
    du_raw   = dur_q >> TICK_SHIFT;
    du_ticks = (du_raw == 16'd0) ? 16'd1 : du_raw;
    total    = {1'b0, st_ticks} + {9'd0, du_ticks};
    mn_ticks = {14'd0, min_delay_us} >> TICK_SHIFT;
    clamp    = (st_ticks < mn_ticks);
    rest     = total - {1'b0, mn_ticks};
    if (clamp) begin
      st16 = mn_ticks[15:0];
      du16 = (total > {1'b0, mn_ticks}) ? rest[15:0] : 16'd1;
    end else begin
      st16 = st_ticks[15:0];
      du16 = du_ticks;
    end
    start_new = cnt + st16;
    end_new   = start_new + du16;
  end

  function automatic slot_upd_t on_match(status_t st, logic cl, logic [15:0] cv,
                                         logic [15:0] ec, logic [15:0] now);
    slot_upd_t u;
    u.status  = st;
    u.coil    = cl;
    u.compare = cv;
    case (st)
      ST_PENDING: begin
        u.status  = ST_RUNNING;
        u.coil    = 1'b1;
        u.compare = ec;
        if (reached(now, ec)) begin
          u.status = ST_OFF;
          u.coil   = 1'b0;
        end
      end
      ST_RUNNING: begin
        u.status = ST_OFF;
        u.coil   = 1'b0;
      end
      default: ;
    endcase
    return u;
  endfunction

  assign tick_upd[0] = on_match(status[0], coil[0], cmp[0], end_cmp[0], cnt + 16'd1);
  assign tick_upd[1] = on_match(status[1], coil[1], cmp[1], end_cmp[1], cnt + 16'd1);
  // A fresh schedule is always pending, so a late start runs the pending branch.
  assign sched_upd   = on_match(ST_PENDING, 1'b1, start_new, end_new, cnt);

  always_comb begin
    cnt_next       = cnt;
    status_next    = status;
    coil_next      = coil;
    cmp_next       = cmp;
    end_cmp_next   = end_cmp;
    slot_chan_next = slot_chan;
    case (cmd_q)
      CMD_TICK: begin
        cnt_next = cnt + 16'd1;
        if (cnt_next == cmp[0]) begin
          status_next[0] = tick_upd[0].status;
          coil_next[0]   = tick_upd[0].coil;
          cmp_next[0]    = tick_upd[0].compare;
        end
        if (cnt_next == cmp[1]) begin
          status_next[1] = tick_upd[1].status;
          coil_next[1]   = tick_upd[1].coil;
          cmp_next[1]    = tick_upd[1].compare;
        end
      end
      CMD_SCHEDULE: begin
        if (chan_q > channel_limit) begin
          status_next[sel] = ST_OFF;
        end else begin
          // Rescheduling a running slot first clears it.
          if (status[sel] == ST_RUNNING) begin
            if (slot_chan[sel] == CHANNEL_COIL_ONE) begin
              coil_next[0] = 1'b0;
            end else if (slot_chan[sel] == CHANNEL_COIL_TWO) begin
              coil_next[1] = 1'b0;
            end
          end
          end_cmp_next[sel]   = end_new;
          slot_chan_next[sel] = chan_q;
          if (reached(cnt, start_new)) begin
            status_next[sel] = sched_upd.status;
            coil_next[sel]   = sched_upd.coil;
            cmp_next[sel]    = sched_upd.compare;
          end else begin
            status_next[sel] = ST_PENDING;
            cmp_next[sel]    = start_new;
          end
        end
      end
      CMD_CLEAR: begin
        status_next[sel] = ST_OFF;
        if (slot_chan[sel] == CHANNEL_COIL_ONE) begin
          coil_next[0] = 1'b0;
        end else if (slot_chan[sel] == CHANNEL_COIL_TWO) begin
          coil_next[1] = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt          <= 16'd0;
      status[0]    <= ST_OFF;
      status[1]    <= ST_OFF;
      coil[0]      <= 1'b0;
      coil[1]      <= 1'b0;
      cmp[0]       <= COMPARE_RESET;
      cmp[1]       <= COMPARE_RESET;
      end_cmp[0]   <= 16'd0;
      end_cmp[1]   <= 16'd0;
      slot_chan[0] <= CHANNEL_COIL_ONE;
      slot_chan[1] <= CHANNEL_COIL_TWO;
    end else if (advance) begin
      cnt       <= cnt_next;
      status    <= status_next;
      coil      <= coil_next;
      cmp       <= cmp_next;
      end_cmp   <= end_cmp_next;
      slot_chan <= slot_chan_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      coil_one    <= coil_next[0];
      coil_two    <= coil_next[1];
      status_one  <= status_next[0];
      status_two  <= status_next[1];
      timer_count <= cnt_next;
    end
  end

endmodule

// ===== sv/idcs_checker.sv =====
`include "ignition_dwell_compare_scheduler_macros.svh"

module idcs_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        coil_one,
  input logic        coil_two,
  input logic [1:0]  status_one,
  input logic [1:0]  status_two,
  input logic [15:0] timer_count
);
  import idcs_pkg::*;

  // A running slot always has its coil charging.
  `IDCS_ASSERT(running_one_drives, out_valid && status_one == ST_RUNNING |-> coil_one, "slot one running with coil one off")
  `IDCS_ASSERT(running_two_drives, out_valid && status_two == ST_RUNNING |-> coil_two, "slot two running with coil two off")

  // Input back-pressure only comes from a result that is waiting to be taken.
  `IDCS_ASSERT(ready_only_on_stall, !in_ready |-> out_valid && !out_ready, "input stalled without a stalled result")

  // A stalled result holds its value.
  `IDCS_ASSERT(result_holds, out_valid && !out_ready |=> out_valid && $stable(timer_count) && $stable(status_one) && $stable(status_two), "stalled result changed")

  // Nothing is offered in the cycle after reset.
  `IDCS_ASSERT_ALWAYS(quiet_after_reset, !rst && $past(rst) |-> !out_valid, "result valid right after reset")

endmodule

bind ignition_dwell_compare_scheduler idcs_checker u_idcs_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .coil_one    (coil_one),
  .coil_two    (coil_two),
  .status_one  (status_one),
  .status_two  (status_two),
  .timer_count (timer_count)
);
